// ===== rtl/swcf_pkg.sv =====
package swcf_pkg;

	localparam int WINDOW_MAX_DEF  = 128;
	localparam int PROFILE_MAX_DEF = 8;

	// Configuration register indexes, each register on an 8-byte boundary.
	typedef enum logic [1:0] {
		REG_WINDOW_LENGTH    = 2'd0,
		REG_PROFILE_ENTRIES  = 2'd1,
		REG_PROFILE_CHARS    = 2'd2,
		REG_PROFILE_MINIMUMS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic        found;
		logic [31:0] position;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  window_length;
		logic [3:0]  profile_entries;
		logic [63:0] profile_chars;
		logic [63:0] profile_minimums;
	} cfg_t;

	// Controls for the counter lanes for one processed byte.
	typedef struct packed {
		logic en;
		logic clr;
		logic leaving;
	} lane_ctl_t;

endpackage

// ===== rtl/sliding_window_char_count_filter.sv =====
// Sliding-window character count filter. Bytes of a string arrive one word per
// cycle on the input channel unless stalled, with last_byte set on the final
// byte. The block keeps the most recent window_length bytes in a ring memory and
// one counter per profile character. When the window is full and every active
// counter has reached its minimum, one word with found=1 and the index of the
// window's newest byte comes out, and the rest of the string produces nothing. A
// string without a candidate gives one word with found=0 at its last byte. The
// block accepts one byte per cycle without gaps while the output is not stalled;
// a result passes stage s1 into the output register. The ring memory's
// registered read is issued when a byte is accepted, so that the leaving byte is
// ready in the following cycle, and a byte written in that same cycle is
// forwarded around the memory. The ring needs no clearing pass after reset.
// Registers are written over the APB port at byte address 8*i and should be
// changed only between strings.
module sliding_window_char_count_filter import swcf_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int PROFILE_MAX = PROFILE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam logic [8:0] M9 = 9'(WINDOW_MAX);
	localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW_MAX - 1);

	cfg_t cfg;

	swcf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The window length in use is the register clamped to 1..WINDOW_MAX.
	logic [7:0] w_used;
	always_comb begin
		if (cfg.window_length == 8'd0) begin
			w_used = 8'd1;
		end else if (cfg.window_length > 8'(WINDOW_MAX)) begin
			w_used = 8'(WINDOW_MAX);
		end else begin
			w_used = cfg.window_length;
		end
	end

	// Stage s1 holds the accepted word, its ring slot and the forwarding flag.
	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic [SW-1:0] slot_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_byte_s1;

	// Slot that the next accepted byte will take in the ring.
	logic [SW-1:0] slot_q;
	logic [31:0]   byte_index_q;
	logic          cand_q;

	logic          out_valid_q;
	out_word_t     out_word_q;

	logic          out_free;
	logic          adv;
	logic          accept;
	logic          proc;
	logic          ring_we;
	logic [8:0]    rsum;
	logic [SW-1:0] raddr;
	logic [7:0]    rdata;
	logic [7:0]    old_byte;
	logic          leaving;
	logic          full;
	logic          ok;
	logic          hit;
	logic          produce;
	lane_ctl_t     lane_ctl;

	// The output register is free when empty or when its word is taken now.
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Once a candidate is reported, the remaining bytes of the string are
	// dropped without touching the ring or the counters.
	assign proc    = !cand_q;
	assign ring_we = adv && proc;

	// Address of the byte that leaves the window when the new byte enters.
	assign rsum  = 9'(slot_q) + M9 - 9'(w_used);
	assign raddr = (rsum >= M9) ? SW'(rsum - M9) : SW'(rsum);

	swcf_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (slot_s1),
		.wdata (data_s1),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign old_byte = fwd_s1 ? fwd_byte_s1 : rdata;

	assign leaving = byte_index_q >= {24'd0, w_used};
	assign full    = ({1'b0, byte_index_q} + 33'd1) >= {25'd0, w_used};

	assign lane_ctl.en      = adv && proc;
	assign lane_ctl.clr     = adv && last_s1;
	assign lane_ctl.leaving = leaving;

	swcf_lanes #(
		.PROFILE_MAX (PROFILE_MAX)
	) u_lanes (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (lane_ctl),
		.data_byte        (data_s1),
		.old_byte         (old_byte),
		.profile_chars    (cfg.profile_chars),
		.profile_minimums (cfg.profile_minimums),
		.profile_entries  (cfg.profile_entries),
		.ok               (ok)
	);

	assign hit     = proc && full && ok;
	assign produce = hit || (proc && last_s1);

	// Input side: capture the word and track the ring slot for the string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			slot_q   <= '0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= ring_we && (slot_s1 == raddr);
				if (in_word.last_byte || slot_q == SLOT_LAST) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + SW'(1);
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1     <= in_word.data_byte;
			last_s1     <= in_word.last_byte;
			slot_s1     <= slot_q;
			fwd_byte_s1 <= data_s1;
		end
	end

	// Per-string state: byte index (saturating) and the reported flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= 32'd0;
			cand_q       <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				byte_index_q <= 32'd0;
				cand_q       <= 1'b0;
			end else if (proc) begin
				if (byte_index_q != 32'hFFFF_FFFF) begin
					byte_index_q <= byte_index_q + 32'd1;
				end
				cand_q <= hit;
			end
		end
	end

	// Output register: a word stays until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_word_q.found    <= hit;
			out_word_q.position <= hit ? byte_index_q : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ===== rtl/swcf_ram.sv =====
module swcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/swcf_cfg.sv =====
module swcf_cfg import swcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length    <= 8'd1;
			cfg_q.profile_entries  <= 4'd0;
			cfg_q.profile_chars    <= 64'd0;
			cfg_q.profile_minimums <= 64'd0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_WINDOW_LENGTH:    cfg_q.window_length    <= pwdata[7:0];
				REG_PROFILE_ENTRIES:  cfg_q.profile_entries  <= pwdata[3:0];
				REG_PROFILE_CHARS:    cfg_q.profile_chars    <= pwdata;
				REG_PROFILE_MINIMUMS: cfg_q.profile_minimums <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WINDOW_LENGTH:    prdata = {56'd0, cfg_q.window_length};
			REG_PROFILE_ENTRIES:  prdata = {60'd0, cfg_q.profile_entries};
			REG_PROFILE_CHARS:    prdata = cfg_q.profile_chars;
			REG_PROFILE_MINIMUMS: prdata = cfg_q.profile_minimums;
			default:              prdata = 64'd0;
		endcase
	end

endmodule

// ===== rtl/swcf_lanes.sv =====
module swcf_lanes import swcf_pkg::*; #(
	parameter int PROFILE_MAX = PROFILE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lane_ctl_t   ctl,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  old_byte,
	input  logic [63:0] profile_chars,
	input  logic [63:0] profile_minimums,
	input  logic [3:0]  profile_entries,
	output logic        ok
);

	logic [7:0] cnt_q   [PROFILE_MAX];
	logic [7:0] cnt_nxt [PROFILE_MAX];
	logic [3:0] active;

	assign active = (profile_entries > 4'(PROFILE_MAX)) ? 4'(PROFILE_MAX) : profile_entries;

	// Each lane adds the entering byte first, then removes the leaving one.
	always_comb begin
		logic [7:0] c1;
		logic [7:0] ch;
		ok = 1'b1;
		for (int k = 0; k < PROFILE_MAX; k++) begin
			ch = profile_chars[8*k +: 8];
			c1 = cnt_q[k];
			if (data_byte == ch && c1 != 8'hFF) begin
				c1 = c1 + 8'd1;
			end
			if (ctl.leaving && old_byte == ch && c1 != 8'd0) begin
				c1 = c1 - 8'd1;
			end
			cnt_nxt[k] = c1;
			if (4'(k) < active && c1 < profile_minimums[8*k +: 8]) begin
				ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PROFILE_MAX; k++) begin
				cnt_q[k] <= 8'd0;
			end
		end else if (ctl.clr) begin
			for (int k = 0; k < PROFILE_MAX; k++) begin
				cnt_q[k] <= 8'd0;
			end
		end else if (ctl.en) begin
			cnt_q <= cnt_nxt;
		end
	end

endmodule

// ===== rtl/swcf_checker.sv =====
module swcf_checker import swcf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input out_word_t out_word,
	input logic      out_valid,
	input logic      out_stall,
	input logic      pready
);

	// A held result word must not change or vanish.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("held result word changed");

	// A not-found word always carries position zero.
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.found |-> out_word.position == 32'd0)
		else $error("not-found word with nonzero position");

	// The input side only stalls when a result is waiting to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// With the output free and no input word offered, the input is not stalled in the next cycle.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall && !in_valid |=> !in_stall)
		else $error("input stalled after output was drained");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind sliding_window_char_count_filter swcf_checker u_swcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_word  (out_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pready    (pready)
);
